// ===== rtl/core/lpfr_pkg.sv =====
// shared constants and types for the length-prefixed frame receiver
// no dependencies; imported by lpfr_decoder and length_prefixed_frame_receiver
package lpfr_pkg;

  // largest frame length accepted, id byte included
  localparam int unsigned MAX_LEN = 256;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 9;
  localparam int TICK_W = 16;
  localparam int GATHER_W = 32;

  // operation codes carried on s_tuser
  typedef enum logic [OP_W-1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } lpfr_op_t;

  // one result item
  typedef struct packed {
    logic              timed_out;
    logic              length_rejected;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] msg_id;
    logic              packet_ready;
    logic [BYTE_W-1:0] payload_data;
    logic [BYTE_W-1:0] payload_index;
    logic              payload_valid;
  } lpfr_result_t;

endpackage

// ===== rtl/core/lpfr_decoder.sv =====
// frame parsing state and the per-transaction next-state and result logic
// depends on lpfr_pkg
module lpfr_decoder
  import lpfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  lpfr_op_t            operation,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  logic [TICK_W-1:0]   time_limit,
  output lpfr_result_t        result
);

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_MSGID   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_READY   = 2'd3
  } phase_t;

  localparam logic [GATHER_W-1:0] MaxLenWide = GATHER_W'(MAX_LEN);
  localparam logic [TICK_W-1:0]   TickMax    = '1;

  phase_t              phase, phase_next;
  logic [GATHER_W-1:0] length_gather, length_gather_next;
  logic [1:0]          length_bytes_seen, length_bytes_seen_next;
  logic [LEN_W-1:0]    frame_len_reg, frame_len_reg_next;
  logic [LEN_W-1:0]    byte_count, byte_count_next;
  logic [BYTE_W-1:0]   msg_id_reg, msg_id_reg_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;

  logic [GATHER_W-1:0] gather_shift;
  logic [LEN_W-1:0]    count_inc;
  logic                tmo;

  always_comb begin
    tmo          = tick_count > time_limit;
    gather_shift = {length_gather[GATHER_W-BYTE_W-1:0], rx_byte};
    count_inc    = byte_count + LEN_W'(1);

    phase_next             = tmo ? PH_LENGTH : phase;
    length_gather_next     = tmo ? '0 : length_gather;
    length_bytes_seen_next = tmo ? '0 : length_bytes_seen;
    tick_count_next        = tmo ? '0 : tick_count;
    frame_len_reg_next     = frame_len_reg;
    byte_count_next        = byte_count;
    msg_id_reg_next        = msg_id_reg;

    result                 = '0;
    result.timed_out       = tmo;

    case (operation)
      OP_BYTE: begin
        case (phase_next)
          PH_LENGTH: begin
            if (length_bytes_seen_next == 2'd3) begin
              length_gather_next     = '0;
              length_bytes_seen_next = '0;
              if (gather_shift == '0 || gather_shift > MaxLenWide) begin
                result.length_rejected = 1'b1;
              end else begin
                frame_len_reg_next = gather_shift[LEN_W-1:0];
                phase_next         = PH_MSGID;
              end
            end else begin
              length_gather_next     = tmo ? {{(GATHER_W-BYTE_W){1'b0}}, rx_byte}
                                           : gather_shift;
              length_bytes_seen_next = length_bytes_seen_next + 2'd1;
            end
          end
          PH_MSGID: begin
            msg_id_reg_next = rx_byte;
            byte_count_next = LEN_W'(1);
            phase_next      = (frame_len_reg <= LEN_W'(1)) ? PH_READY : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            result.payload_valid = 1'b1;
            result.payload_index = byte_count[BYTE_W-1:0];
            result.payload_data  = rx_byte;
            byte_count_next      = count_inc;
            if (count_inc >= frame_len_reg) begin
              phase_next = PH_READY;
            end
          end
          default: begin
          end
        endcase
      end
      OP_TICK: begin
        if (tick_count_next != TickMax) begin
          tick_count_next = tick_count_next + TICK_W'(1);
        end
      end
      OP_RELEASE: begin
        phase_next             = PH_LENGTH;
        length_gather_next     = '0;
        length_bytes_seen_next = '0;
      end
      default: begin
      end
    endcase

    // a held frame keeps the timer at zero
    if (phase_next == PH_READY) begin
      tick_count_next = '0;
    end

    result.packet_ready = phase_next == PH_READY;
    result.msg_id       = msg_id_reg_next;
    result.frame_length = frame_len_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LENGTH;
      length_gather     <= '0;
      length_bytes_seen <= '0;
      frame_len_reg     <= '0;
      byte_count        <= '0;
      msg_id_reg        <= '0;
      tick_count        <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      length_gather     <= length_gather_next;
      length_bytes_seen <= length_bytes_seen_next;
      frame_len_reg     <= frame_len_reg_next;
      byte_count        <= byte_count_next;
      msg_id_reg        <= msg_id_reg_next;
      tick_count        <= tick_count_next;
    end
  end

endmodule

// ===== rtl/core/length_prefixed_frame_receiver.sv =====
// length-prefixed frame receiver: stream ports, time limit register, result register
// depends on lpfr_pkg and lpfr_decoder
//
//   channel   direction  handshake          contents
//   s_*       in         s_tvalid/s_tready  tdata rx_byte, tuser operation
//   m_*       out        m_tvalid/m_tready  tdata result fields, tuser payload_valid
//   cfg_*     in         cfg_wr_en          time_limit
//
// one transaction per cycle while s_tready is high; the result is registered and appears in the cycle after acceptance
// the parse state updates in the accepting cycle, so the next item may follow at once
// s_tready drops only while a result is held and m_tready is low
// rst is synchronous: gathering restarts, time_limit and all counters clear
module length_prefixed_frame_receiver
  import lpfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] payload_index, [15:8] payload_data,
                                 // [16] packet_ready, [24:17] msg_id,
                                 // [33:25] frame_length, [34] length_rejected,
                                 // [35] timed_out, [39:36] zero
  output logic        m_tuser,   // [0] payload_valid
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [TICK_W-1:0] time_limit;
  logic              accept;
  lpfr_result_t      result_next;
  lpfr_result_t      result;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  lpfr_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (lpfr_op_t'(s_tuser)),
    .rx_byte    (s_tdata),
    .time_limit (time_limit),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_limit <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        time_limit <= cfg_wr_data;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_tuser = result.payload_valid;
  assign m_tdata = {4'd0, result.timed_out, result.length_rejected, result.frame_length,
                    result.msg_id, result.packet_ready, result.payload_data,
                    result.payload_index};

  // every accepted transaction yields a result next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted transaction produced no result");

  // a timeout restarts gathering and a rejection only comes while gathering, so no payload byte can come with either
  a_no_payload_on_timeout: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !result.timed_out && !result.length_rejected)
    else $error("payload byte delivered together with timeout or rejection");

  // a rejected length leaves the block gathering, never ready
  a_reject_not_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.length_rejected |-> !result.packet_ready)
    else $error("rejected length with frame ready");

  // a held result is only replaced after the sink has taken it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !accept)
    else $error("result overwritten while stalled");

endmodule

// ===== bench/length_prefixed_frame_receiver_tb.sv =====
// self-checking bench for length_prefixed_frame_receiver: directed and random byte,
// tick and release streams against a behavioural predictor under varied flow control
// depends on lpfr_pkg and the receiver rtl
module length_prefixed_frame_receiver_tb;
  import lpfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 60_000;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    lpfr_op_t   op;
    logic [7:0] data;
  } rx_item_t;

  typedef enum logic [1:0] {RX_LEN, RX_ID, RX_PAYLOAD, RX_HELD} rx_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // [7:0] rx_byte
  logic [1:0]  s_tuser = OP_BYTE; // [1:0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [7:0] index, [15:8] data, [16] ready, [24:17] msg_id,
                                  // [33:25] length, [34] rejected, [35] timed_out
  logic        m_tuser;           // [0] payload_valid
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  length_prefixed_frame_receiver dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // items waiting to be offered, and deframer results still owed by the block
  rx_item_t     rx_items[$];
  lpfr_result_t results_due[$];
  int           items_queued = 0;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  logic         long_hold = 1'b0;
  int           hold_count = 0;
  lpfr_result_t got_res;
  lpfr_result_t want_res;

  // predictor state
  logic [15:0]  limit_cfg = 16'd0;
  rx_state_t    rx_state = RX_LEN;
  logic [31:0]  len_shift = 32'd0;
  int unsigned  len_count = 0;
  logic [8:0]   frame_len = 9'd0;
  int unsigned  payload_pos = 0;
  logic [7:0]   id_reg = 8'd0;
  logic [15:0]  tick_cnt = 16'd0;

  function automatic void drop_partial();
    rx_state  = RX_LEN;
    len_shift = 32'd0;
    len_count = 0;
  endfunction

  function automatic lpfr_result_t deframe_step(lpfr_op_t op, logic [7:0] b);
    lpfr_result_t r;
    logic [31:0]  len;
    r = '0;
    if (tick_cnt > limit_cfg) begin
      drop_partial();
      tick_cnt = 16'd0;
      r.timed_out = 1'b1;
    end
    case (op)
      OP_BYTE: begin
        case (rx_state)
          RX_LEN: begin
            len_shift = {len_shift[23:0], b};
            len_count++;
            if (len_count >= 4) begin
              len = len_shift;
              drop_partial();
              if (len == 0 || len > MAX_LEN) begin
                r.length_rejected = 1'b1;
              end else begin
                frame_len = len[8:0];
                rx_state = RX_ID;
              end
            end
          end
          RX_ID: begin
            id_reg = b;
            payload_pos = 1;
            rx_state = (frame_len <= 1) ? RX_HELD : RX_PAYLOAD;
          end
          RX_PAYLOAD: begin
            r.payload_valid = 1'b1;
            r.payload_index = payload_pos[7:0];
            r.payload_data = b;
            payload_pos++;
            if (payload_pos >= frame_len) rx_state = RX_HELD;
          end
          default: ;  // bytes are dropped while a frame is held
        endcase
      end
      OP_TICK: begin
        if (tick_cnt != 16'hFFFF) tick_cnt++;
      end
      OP_RELEASE: drop_partial();
      default: ;
    endcase
    if (rx_state == RX_HELD) tick_cnt = 16'd0;
    r.packet_ready = (rx_state == RX_HELD);
    r.msg_id = id_reg;
    r.frame_length = frame_len;
    return r;
  endfunction

  function automatic string show(lpfr_result_t r);
    return $sformatf("pv=%0d idx=%0d data=%02h rdy=%0d id=%02h len=%0d rej=%0d tmo=%0d",
                     r.payload_valid, r.payload_index, r.payload_data, r.packet_ready,
                     r.msg_id, r.frame_length, r.length_rejected, r.timed_out);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sender: predict on every accepted transaction, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        results_due.push_back(deframe_step(lpfr_op_t'(s_tuser), s_tdata));
      if (!s_tvalid || s_tready) begin
        if (rx_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= rx_items[0].data;
          s_tuser <= rx_items[0].op;
          void'(rx_items.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res = {m_tdata[35:0], m_tuser};
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show(got_res));
        end else begin
          want_res = results_due.pop_front();
          if (got_res !== want_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch\n  expected %s\n  actual   %s",
                       show(want_res), show(got_res));
          end
        end
      end
      m_tready <= !long_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (long_hold) hold_count <= hold_count + 1;
    else hold_count <= 0;
  end

  task automatic push_item(lpfr_op_t op, logic [7:0] b);
    rx_items.push_back('{op: op, data: b});
    items_queued++;
  endtask

  task automatic push_length(logic [31:0] len_word);
    for (int i = 3; i >= 0; i--) push_item(OP_BYTE, len_word[8*i +: 8]);
  endtask

  // occasional ticks and idle codes between frame bytes
  task automatic sprinkle();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 7) push_item(OP_TICK, 8'($urandom));
    else if (r == 7) push_item(OP_NONE, 8'($urandom));
  endtask

  function automatic logic [31:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return 32'd0;
    if (r < 9) return $urandom_range(1) ? $urandom : 32'd257 + $urandom_range(300);
    if (r < 13) return 32'd1;
    if (r == 13) return 32'd256;
    if (r == 14) return $urandom_range(13, 255);
    return $urandom_range(2, 12);
  endfunction

  task automatic queue_frame(logic [31:0] len_word);
    for (int i = 3; i >= 0; i--) begin
      sprinkle();
      push_item(OP_BYTE, len_word[8*i +: 8]);
    end
    if (len_word == 0 || len_word > MAX_LEN) return;
    sprinkle();
    push_item(OP_BYTE, 8'($urandom));
    for (int p = 1; p < len_word; p++) begin
      if ($urandom_range(99) < 3) begin
        // abandon the frame part way
        push_item(OP_RELEASE, 8'($urandom));
        return;
      end
      sprinkle();
      push_item(OP_BYTE, 8'($urandom));
    end
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 3))
        push_item(lpfr_op_t'($urandom_range(3)), 8'($urandom));
    if ($urandom_range(99) < 92) push_item(OP_RELEASE, 8'($urandom));
  endtask

  task automatic wait_idle();
    while (rx_items.size() > 0 || s_tvalid || results_due.size() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_limit(logic [15:0] v);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_cfg = v;
  endtask

  task automatic run_random(int idle_pct, int stall, logic [15:0] lim, int n, bit big);
    int target;
    program_limit(lim);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    target = items_queued + n;
    if (big) queue_frame(32'd256);
    while (items_queued < target) begin
      if ($urandom_range(99) < 8) begin
        // stray items, then a release to get back in step
        repeat ($urandom_range(1, 3))
          push_item(lpfr_op_t'($urandom_range(3)), 8'($urandom));
        push_item(OP_RELEASE, 8'($urandom));
      end
      queue_frame(pick_length());
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: no timeouts, lengths at both edges, single-byte frame, held-frame drops
    program_limit(16'hFFFF);
    push_item(OP_NONE, 8'hFF);
    push_item(OP_RELEASE, 8'h00);
    push_length(32'd0);
    push_length(32'd257);
    push_length(32'd1);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'hAA);
    push_item(OP_TICK, 8'h00);
    push_item(OP_RELEASE, 8'h00);
    push_length(32'd3);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_RELEASE, 8'hFF);

    // directed timeouts with a zero limit: during length, during payload, none when held
    program_limit(16'd0);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_TICK, 8'h00);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_RELEASE, 8'h00);
    push_length(32'd5);
    push_item(OP_BYTE, 8'h07);
    push_item(OP_TICK, 8'h00);
    push_item(OP_BYTE, 8'h11);
    push_item(OP_RELEASE, 8'h00);
    push_length(32'd1);
    push_item(OP_BYTE, 8'h01);
    push_item(OP_TICK, 8'h00);
    push_item(OP_BYTE, 8'h22);
    push_item(OP_RELEASE, 8'h00);

    run_random(0, 0, 16'd6, 325, 1'b0);
    run_random(56, 0, 16'($urandom_range(1, 20)), 325, 1'b0);
    run_random(0, 56, 16'hFFFF, 325, 1'b1);
    run_random(21, 21, 16'd2, 325, 1'b0);

    // receiver held off while the sender keeps offering, so the input backs up
    program_limit(16'd40);
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (12) queue_frame($urandom_range(2, 6));
    while (hold_count < LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
    wait_idle();

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
